>>> hw/rtl/jfps_pkg.sv
// jfps_pkg: shared types and constants for the jacobi five-point sweep
// no dependencies; used by jfps_calc and jacobi_five_point_sweep
package jfps_pkg;

  localparam int MAX_GRID   = 1024;
  localparam int VALUE_BITS = 32;
  localparam int STEP_BITS  = 32;
  localparam int SIZE_BITS  = 11;
  localparam int ADDR_BITS  = $clog2(MAX_GRID);
  localparam int COUNT_BITS = ADDR_BITS + 1;
  localparam int PROD_BITS  = VALUE_BITS + STEP_BITS;
  localparam int SUM_BITS   = VALUE_BITS + 2;
  localparam int TOTAL_BITS = VALUE_BITS + 3;

  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 2;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GRID_SIZE    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_SQUARED = 2'd1;

  localparam logic [SIZE_BITS-1:0] GRID_RESET = 11'd64;
  localparam logic [STEP_BITS-1:0] STEP_RESET = 32'd1032444;
  localparam logic [COUNT_BITS-1:0] GRID_MIN  = COUNT_BITS'(2);
  localparam logic [COUNT_BITS-1:0] GRID_MAX  = COUNT_BITS'(MAX_GRID);

  // saturation bounds at the width of the rounded sum
  localparam logic signed [TOTAL_BITS-1:0] VAL_MAX =
    {{(TOTAL_BITS-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [TOTAL_BITS-1:0] VAL_MIN =
    {{(TOTAL_BITS-VALUE_BITS+1){1'b1}}, {(VALUE_BITS-1){1'b0}}};

  typedef struct packed {
    logic                          mode;
    logic signed [VALUE_BITS-1:0]  u_value;
    logic signed [VALUE_BITS-1:0]  f_value;
  } in_req_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0]  new_value;
    logic                          last;
  } out_req_t;

  // stencil operands handed from the line buffers to the arithmetic
  typedef struct packed {
    logic signed [VALUE_BITS-1:0]  rhs;
    logic signed [VALUE_BITS-1:0]  up;
    logic signed [VALUE_BITS-1:0]  down;
    logic signed [VALUE_BITS-1:0]  left;
    logic signed [VALUE_BITS-1:0]  right;
    logic                          last;
  } calc_op_t;

endpackage

>>> hw/rtl/jfps_calc.sv
// jfps_calc: two-stage stencil arithmetic with output register
// depends on jfps_pkg (calc_op_t, out_req_t, widths)
module jfps_calc (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          op_valid,
  input  jfps_pkg::calc_op_t            op,
  input  logic [jfps_pkg::STEP_BITS-1:0] step_squared,
  output logic                          op_ready,
  output logic                          out_valid,
  output jfps_pkg::out_req_t            out_data,
  input  logic                          out_ready
);

  logic                                     s1_valid_r;
  logic                                     s1_valid_nxt;
  logic signed [jfps_pkg::PROD_BITS-1:0]    prod_r;
  logic signed [jfps_pkg::SUM_BITS-1:0]     sum_r;
  logic                                     last_r;
  logic                                     out_valid_r;
  logic                                     out_valid_nxt;
  jfps_pkg::out_req_t                       out_data_r;

  logic                                     out_free;
  logic                                     s1_load;
  logic signed [jfps_pkg::PROD_BITS:0]      prod_full;
  logic signed [jfps_pkg::SUM_BITS-1:0]     sum4;
  logic signed [jfps_pkg::TOTAL_BITS-1:0]   total;
  logic signed [jfps_pkg::TOTAL_BITS-1:0]   rounded;
  logic signed [jfps_pkg::VALUE_BITS-1:0]   sat_value;

  assign out_free = !out_valid_r || out_ready;
  assign op_ready = !s1_valid_r || out_free;
  assign s1_load  = op_valid && op_ready;

  // h^2 is unsigned, so widen it by a zero before the signed multiply
  assign prod_full = op.rhs * $signed({1'b0, step_squared});
  assign sum4 = jfps_pkg::SUM_BITS'(op.up) + jfps_pkg::SUM_BITS'(op.down)
              + jfps_pkg::SUM_BITS'(op.left) + jfps_pkg::SUM_BITS'(op.right);

  // floor(p / 2^32) is the upper half of the product
  always_comb begin
    total = jfps_pkg::TOTAL_BITS'($signed(prod_r[jfps_pkg::PROD_BITS-1:jfps_pkg::STEP_BITS]))
          + jfps_pkg::TOTAL_BITS'(sum_r) + jfps_pkg::TOTAL_BITS'(2);
    rounded = total >>> 2;
    if (rounded > jfps_pkg::VAL_MAX) begin
      sat_value = jfps_pkg::VAL_MAX[jfps_pkg::VALUE_BITS-1:0];
    end else if (rounded < jfps_pkg::VAL_MIN) begin
      sat_value = jfps_pkg::VAL_MIN[jfps_pkg::VALUE_BITS-1:0];
    end else begin
      sat_value = rounded[jfps_pkg::VALUE_BITS-1:0];
    end
  end

  always_comb begin
    if (s1_load) begin
      s1_valid_nxt = 1'b1;
    end else if (out_free) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    out_valid_nxt = out_free ? s1_valid_r : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      prod_r <= prod_full[jfps_pkg::PROD_BITS-1:0];
      sum_r  <= sum4;
      last_r <= op.last;
    end
    if (out_free && s1_valid_r) begin
      out_data_r.new_value <= sat_value;
      out_data_r.last      <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hw/rtl/jacobi_five_point_sweep.sv
// jacobi_five_point_sweep: top level, line buffers, counters and config
// depends on jfps_pkg and jfps_calc
//
//  channel | ports                               | transfer
//  --------+-------------------------------------+--------------------------
//  input   | in_valid, in_ready, in_data         | valid & ready
//  result  | out_valid, out_ready, out_data      | valid & ready
//  config  | cfg_wr_en, cfg_index, cfg_wdata     | write when cfg_wr_en high
//
// one point per cycle; a request is accepted in any cycle the arithmetic
// stage has room. results pass the stage 1 and output registers. line buffer
// reads are issued at the next column address, so the row_above memory has
// two read ports (column and column+1). reset has no clearing
// pass. a stalled result holds the pipe; one more request fits behind it.
module jacobi_five_point_sweep (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  jfps_pkg::in_req_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output jfps_pkg::out_req_t                   out_data,
  input  logic                                 cfg_wr_en,
  input  logic [jfps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [jfps_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

  logic [jfps_pkg::SIZE_BITS-1:0]   grid_size_r;
  logic [jfps_pkg::STEP_BITS-1:0]   step_sq_r;
  logic [jfps_pkg::ADDR_BITS-1:0]   col_r;
  logic [jfps_pkg::ADDR_BITS-1:0]   col_nxt;
  logic [jfps_pkg::COUNT_BITS-1:0]  row_r;
  logic [jfps_pkg::COUNT_BITS-1:0]  row_nxt;
  logic signed [jfps_pkg::VALUE_BITS-1:0] left_r;

  // row_above and {row_two_above, rhs_row_above}
  logic [jfps_pkg::VALUE_BITS-1:0]   above_mem [jfps_pkg::MAX_GRID];
  logic [2*jfps_pkg::VALUE_BITS-1:0] hist_mem  [jfps_pkg::MAX_GRID];
  logic [jfps_pkg::VALUE_BITS-1:0]   center_rd_r;
  logic [jfps_pkg::VALUE_BITS-1:0]   right_rd_r;
  logic [2*jfps_pkg::VALUE_BITS-1:0] hist_rd_r;

  logic [jfps_pkg::COUNT_BITS-1:0]  n_eff;
  logic [jfps_pkg::ADDR_BITS-1:0]   right_addr;
  logic                             col_last;
  logic                             accept;
  logic                             is_flush;
  logic                             skip;
  logic                             step;
  logic                             grid_wr;
  logic signed [jfps_pkg::VALUE_BITS-1:0] down_val;
  logic signed [jfps_pkg::VALUE_BITS-1:0] f_val;
  logic [2*jfps_pkg::VALUE_BITS-1:0] hist_wdata;
  jfps_pkg::calc_op_t               op;
  logic                             op_valid;
  logic                             op_ready;

  always_comb begin
    if (jfps_pkg::COUNT_BITS'(grid_size_r) < jfps_pkg::GRID_MIN) begin
      n_eff = jfps_pkg::GRID_MIN;
    end else if (jfps_pkg::COUNT_BITS'(grid_size_r) > jfps_pkg::GRID_MAX) begin
      n_eff = jfps_pkg::GRID_MAX;
    end else begin
      n_eff = jfps_pkg::COUNT_BITS'(grid_size_r);
    end
  end

  assign in_ready = op_ready;
  assign accept   = in_valid && in_ready;
  assign is_flush = in_data.mode;
  assign col_last = (jfps_pkg::COUNT_BITS'(col_r) + jfps_pkg::COUNT_BITS'(1)) == n_eff;
  // grid points past the grid, and flushes before it ends, change nothing
  assign skip = (!is_flush && row_r >= n_eff) || (is_flush && row_r != n_eff);
  assign step = accept && !skip;
  assign grid_wr = cfg_wr_en && (cfg_index == jfps_pkg::CFG_GRID_SIZE);

  assign down_val = is_flush ? '0 : in_data.u_value;
  assign f_val    = is_flush ? '0 : in_data.f_value;
  // row_two_above takes what row_above held at this column
  assign hist_wdata = {center_rd_r, f_val};

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (!rst_n || grid_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (step) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = (row_r >= n_eff) ? '0 : row_r + jfps_pkg::COUNT_BITS'(1);
      end else begin
        col_nxt = col_r + jfps_pkg::ADDR_BITS'(1);
      end
    end
  end

  assign right_addr = col_nxt + jfps_pkg::ADDR_BITS'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= jfps_pkg::GRID_RESET;
      step_sq_r   <= jfps_pkg::STEP_RESET;
      col_r       <= '0;
      row_r       <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          jfps_pkg::CFG_GRID_SIZE:    grid_size_r <= cfg_wdata[jfps_pkg::SIZE_BITS-1:0];
          jfps_pkg::CFG_STEP_SQUARED: step_sq_r   <= cfg_wdata[jfps_pkg::STEP_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // line buffers: write at the current column, prefetch at the next one
  always_ff @(posedge clk) begin
    if (step) begin
      above_mem[col_r] <= down_val;
      hist_mem[col_r]  <= hist_wdata;
    end
    if (step && col_nxt == col_r) begin
      center_rd_r <= down_val;
      hist_rd_r   <= hist_wdata;
    end else begin
      center_rd_r <= above_mem[col_nxt];
      hist_rd_r   <= hist_mem[col_nxt];
    end
    // on a two-point grid the next right neighbor is the point just written
    if (step && right_addr == col_r) begin
      right_rd_r <= down_val;
    end else begin
      right_rd_r <= above_mem[right_addr];
    end
    if (step) begin
      left_r <= center_rd_r;
    end
  end

  always_comb begin
    op.rhs   = hist_rd_r[jfps_pkg::VALUE_BITS-1:0];
    op.up    = (row_r >= jfps_pkg::COUNT_BITS'(2))
             ? hist_rd_r[2*jfps_pkg::VALUE_BITS-1:jfps_pkg::VALUE_BITS] : '0;
    op.down  = down_val;
    op.left  = (col_r == '0) ? '0 : left_r;
    op.right = col_last ? '0 : right_rd_r;
    op.last  = is_flush && col_last;
  end

  // the first row only fills the buffers
  assign op_valid = step && (row_r != '0);

  jfps_calc u_calc (
    .clk          (clk),
    .rst_n        (rst_n),
    .op_valid     (op_valid),
    .op           (op),
    .step_squared (step_sq_r),
    .op_ready     (op_ready),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .out_ready    (out_ready)
  );

endmodule
